FILE: rtl/chtl_pkg.sv
// Shared constants, codes and types for the chained hash table core.
package chtl_pkg;

	localparam int TABLE_ENTRIES = 8192;
	localparam int HOME_BUCKETS  = 4093;
	localparam int VALUE_WIDTH   = 16;
	localparam int KEY_W         = 32;
	localparam int STATUS_W      = 3;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int HOME_W        = $clog2(HOME_BUCKETS);

	// 2**HOME_W is congruent to FOLD_MUL modulo HOME_BUCKETS
	localparam int FOLD_MUL      = (1 << HOME_W) - HOME_BUCKETS;

	localparam logic [ADDR_W-1:0] OVF_TOP   = ADDR_W'(TABLE_ENTRIES - 1);
	localparam logic [ADDR_W-1:0] OVF_FLOOR = ADDR_W'(HOME_BUCKETS);

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd5;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] link;
	} entry_t;

endpackage

FILE: rtl/chtl_req_if.sv
// Request channel: operation, key and value handle with valid/ready.
interface chtl_req_if;
	import chtl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic signed [KEY_W-1:0] key;
	logic [VALUE_WIDTH-1:0]  value_handle;

	modport source (output valid, output operation, output key, output value_handle,
		input ready);
	modport sink (input valid, input operation, input key, input value_handle,
		output ready);
endinterface

FILE: rtl/chtl_rsp_if.sv
// Response channel: status and found value with valid/ready.
interface chtl_rsp_if;
	import chtl_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [VALUE_WIDTH-1:0] found_value;

	modport source (output valid, output status, output found_value, input ready);
	modport sink (input valid, input status, input found_value, output ready);
endinterface

FILE: rtl/chained_hash_table_lookup_insert_core.sv
// Top level: chained hash table with lookup and insert over one key/link memory.
//
//   channel | dir | transaction carries
//   --------+-----+--------------------------------------
//   req     | in  | operation, key, value_handle
//   rsp     | out | status, found_value
//
// One item at a time: accept, home bucket, one chain entry read per cycle from the
// key/link memory, then a value read (lookup hit) or a link write (overflow insert),
// then the result register; a zero key goes straight to the result register.
// After reset the key/link memory is cleared, one entry a cycle, all 8192 entries,
// with req.ready low. A new item may be accepted while the previous result waits on rsp.
module chained_hash_table_lookup_insert_core (
	input  logic      clk,
	input  logic      arst_n,
	chtl_req_if.sink  req,
	chtl_rsp_if.source rsp
);
	import chtl_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HASH   = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_LINK   = 3'd4;
	localparam logic [2:0] S_VREAD  = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0]             state_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [ADDR_W-1:0]      ovf_q;
	logic                   rsp_valid_q;

	logic                   op_q;
	logic [KEY_W-1:0]       key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [KEY_W-1:0]       last_key_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [VALUE_WIDTH-1:0] res_value_q;
	logic [STATUS_W-1:0]    rsp_status_q;
	logic [VALUE_WIDTH-1:0] rsp_value_q;

	logic [HOME_W-1:0]      home_q;
	logic [ADDR_W-1:0]      home_addr;

	logic                   kl_we;
	logic [ADDR_W-1:0]      kl_waddr;
	entry_t                 kl_wdata;
	logic [ADDR_W-1:0]      kl_raddr;
	entry_t                 kl_rdata;
	logic                   v_we;
	logic [ADDR_W-1:0]      v_waddr;
	logic [VALUE_WIDTH-1:0] v_rdata;

	logic                   accept;
	logic                   load_rsp;
	logic                   hit;
	logic                   chain_end;
	logic                   home_empty;
	logic                   ovf_ok;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign load_rsp   = (state_q == S_RESULT) && (!rsp_valid_q || rsp.ready);
	assign home_addr  = ADDR_W'(home_q);
	assign hit        = (kl_rdata.key == key_q);
	assign chain_end  = (kl_rdata.link == '0);
	assign home_empty = (pos_q == home_addr) && (kl_rdata.key == '0);
	assign ovf_ok     = (ovf_q >= OVF_FLOOR);

	chtl_home u_home (
		.clk    (clk),
		.load   (accept),
		.key    (req.key),
		.home_q (home_q)
	);

	chtl_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_kl_ram (
		.clk   (clk),
		.we    (kl_we),
		.waddr (kl_waddr),
		.wdata (kl_wdata),
		.raddr (kl_raddr),
		.rdata (kl_rdata)
	);

	chtl_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_ENTRIES)
	) u_val_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (val_q),
		.raddr (pos_q),
		.rdata (v_rdata)
	);

	// memory port control
	always_comb begin
		kl_we    = 1'b0;
		kl_waddr = pos_q;
		kl_wdata = '0;
		kl_raddr = pos_q;
		v_we     = 1'b0;
		v_waddr  = pos_q;
		case (state_q)
			S_CLEAR: begin
				kl_we    = 1'b1;
				kl_waddr = clr_q;
			end
			S_HASH: begin
				kl_raddr = home_addr;
			end
			S_WALK: begin
				kl_raddr = kl_rdata.link;
				if (!hit && chain_end && op_q == OP_INSERT) begin
					if (home_empty) begin
						kl_we         = 1'b1;
						kl_wdata.key  = key_q;
						kl_wdata.link = kl_rdata.link;
						v_we          = 1'b1;
					end else if (ovf_ok) begin
						// new overflow entry; predecessor gets linked next cycle
						kl_we        = 1'b1;
						kl_waddr     = ovf_q;
						kl_wdata.key = key_q;
						v_we         = 1'b1;
						v_waddr      = ovf_q;
					end
				end
			end
			S_LINK: begin
				kl_we         = 1'b1;
				kl_wdata.key  = last_key_q;
				kl_wdata.link = ovf_q;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			ovf_q   <= OVF_TOP;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == OVF_TOP) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.key == '0) ? S_RESULT : S_HASH;
					end
				end
				S_HASH: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (hit) begin
						state_q <= (op_q == OP_LOOKUP) ? S_VREAD : S_RESULT;
					end else if (!chain_end) begin
						state_q <= S_WALK;
					end else if (op_q == OP_INSERT && !home_empty && ovf_ok) begin
						state_q <= S_LINK;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_LINK: begin
					ovf_q   <= ovf_q - 1'b1;
					state_q <= S_RESULT;
				end
				S_VREAD: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and walk position
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.operation;
			key_q        <= req.key;
			val_q        <= req.value_handle;
			res_value_q  <= '0;
			res_status_q <= ST_ZERO;
		end
		if (state_q == S_HASH) begin
			pos_q <= home_addr;
		end
		if (state_q == S_WALK) begin
			if (hit) begin
				res_status_q <= (op_q == OP_LOOKUP) ? ST_HIT : ST_DUPLICATE;
			end else if (!chain_end) begin
				pos_q <= kl_rdata.link;
			end else if (op_q == OP_LOOKUP) begin
				res_status_q <= ST_MISS;
			end else if (home_empty || ovf_ok) begin
				res_status_q <= ST_INSERTED;
				last_key_q   <= kl_rdata.key;
			end else begin
				res_status_q <= ST_FULL;
			end
		end
		if (state_q == S_VREAD) begin
			res_value_q <= v_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_status_q <= res_status_q;
			rsp_value_q  <= res_value_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_value = rsp_value_q;
endmodule

FILE: rtl/chtl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/chtl_home.sv
// Home bucket unit: unsigned key modulo HOME_BUCKETS by digit folding, registered.
module chtl_home (
	input  logic                        clk,
	input  logic                        load,
	input  logic [chtl_pkg::KEY_W-1:0]  key,
	output logic [chtl_pkg::HOME_W-1:0] home_q
);
	import chtl_pkg::*;

	localparam int HI0_W = KEY_W - HOME_W;
	localparam int X1_W  = HI0_W + 2;
	localparam int X2_W  = HOME_W + 1;

	logic [X1_W-1:0]   x1;
	logic [X2_W-1:0]   x2;
	logic [X2_W-1:0]   x3;
	logic [X2_W-1:0]   x4;

	// each fold replaces hi*2**HOME_W by hi*FOLD_MUL, same residue
	always_comb begin
		x1 = X1_W'(key[KEY_W-1:HOME_W]) * X1_W'(FOLD_MUL) + X1_W'(key[HOME_W-1:0]);
		x2 = X2_W'(x1[X1_W-1:HOME_W]) * X2_W'(FOLD_MUL) + X2_W'(x1[HOME_W-1:0]);
		x3 = X2_W'(x2[X2_W-1:HOME_W]) * X2_W'(FOLD_MUL) + X2_W'(x2[HOME_W-1:0]);
		x4 = (x3 >= X2_W'(HOME_BUCKETS)) ? x3 - X2_W'(HOME_BUCKETS) : x3;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			home_q <= x4[HOME_W-1:0];
		end
	end
endmodule

FILE: rtl/chtl_checker.sv
// Port-level checker for the hash table core, bound to the top level.
module chtl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [chtl_pkg::STATUS_W-1:0]    rsp_status,
	input logic [chtl_pkg::VALUE_WIDTH-1:0] rsp_found_value
);
	import chtl_pkg::*;

	logic [1:0] pend_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_fire && !rsp_fire) begin
			pend_q <= pend_q + 1'b1;
		end else if (rsp_fire && !req_fire) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request accepted while previous item still in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_value))
		else $error("stalled response changed");

	a_value_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_HIT |-> rsp_found_value == '0)
		else $error("nonzero found_value without a hit");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an accepted request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two transactions outstanding");
endmodule

bind chained_hash_table_lookup_insert_core chtl_checker u_chtl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value)
);
